// ----- rtl/extended80_to_double_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the extended80_to_double checker
// ----------------------------------------------------------------------------
`ifndef EXTENDED80_TO_DOUBLE_ASSERT_SVH
`define EXTENDED80_TO_DOUBLE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define E80D_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// plain invariant outside reset
`define E80D_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

`endif

// ----- rtl/e80d_pkg.sv -----
// ----------------------------------------------------------------------------
// e80d_pkg
// Constants shared by the extended-to-double converter.
// ----------------------------------------------------------------------------
package e80d_pkg;
	localparam int PIPE_DEPTH = 5;
	localparam logic [14:0] EXT_EXP_MAX = 15'h7FFF;
	// 16383 - 1023: extended bias less double bias
	localparam logic signed [17:0] BIAS_DIFF = 18'sd15360;
	localparam logic [10:0] DBL_EXP_MAX = 11'h7FF;
	localparam logic [63:0] DBL_INF = 64'h7FF0_0000_0000_0000;
	localparam logic [6:0] SH_NORMAL = 7'd11;
	localparam logic [6:0] SH_LIMIT = 7'd64;
endpackage

// ----- rtl/extended80_to_double.sv -----
// ----------------------------------------------------------------------------
// extended80_to_double
// 80-bit extended float to IEEE binary64, round to nearest even.
// ----------------------------------------------------------------------------
// One request is taken in every cycle in which start is high; busy is always
// low. Each result appears on double_bits with done high for one cycle, in
// request order, once it has passed the stages below. There is no hold-off on
// the result side: done is a one-cycle strobe and the result must be taken
// then. The five stages are:
// input capture, leading-zero count, normalising shift, alignment shift with
// guard/sticky, and rounding. Exponent 0x7FFF gives signed infinity, a zero
// mantissa signed zero.
module extended80_to_double (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] ext_sign_exponent,
	input  logic [63:0] ext_mantissa,
	output logic        done,
	output logic [63:0] double_bits
);
	import e80d_pkg::*;

	typedef struct packed {
		logic sign;
		logic inf;
		logic zero;
	} flags_t;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	flags_t            flg_s1, flg_s2, flg_s3, flg_s4;
	logic [14:0]       ex_s1, ex_s2;
	logic [63:0]       mant_s1, mant_s2, nm_s3;
	logic [5:0]        lz_s2;
	logic signed [17:0] be_s3, be_s4;
	logic [52:0]       q_s4;
	logic              grd_s4, stk_s4, sub_s4, under_s4;
	logic [63:0]       res_s5;

	logic [5:0]        lz_c;
	logic [6:0]        sh_c;
	logic [127:0]      ext_c;
	logic signed [17:0] shr_c;
	logic [53:0]       qr_c;
	logic [10:0]       bex_c;
	logic signed [17:0] be_inc_c;
	logic [63:0]       res_c;

	assign busy = 1'b0;

	// highest set bit; zero mantissa is flagged separately
	always_comb begin
		lz_c = '0;
		for (int i = 0; i < 64; i++) begin
			if (mant_s1[i]) lz_c = 6'(63 - i);
		end
	end

	always_comb begin
		shr_c = 18'sd12 - be_s3;
		if (be_s3 >= 18'sd1) sh_c = SH_NORMAL;
		else if (shr_c > 18'sd64) sh_c = SH_LIMIT;
		else sh_c = shr_c[6:0];
		ext_c = {nm_s3, 64'd0} >> sh_c;
	end

	always_comb begin
		qr_c = {1'b0, q_s4} + 54'(grd_s4 & (stk_s4 | q_s4[0]));
		be_inc_c = be_s4 + 18'sd1;
		bex_c = be_s4[10:0];
		if (flg_s4.inf) begin
			res_c = {flg_s4.sign, DBL_INF[62:0]};
		end else if (flg_s4.zero || under_s4) begin
			res_c = {flg_s4.sign, 63'd0};
		end else if (sub_s4) begin
			// carry into bit 52 lands on the smallest normal by itself
			res_c = {flg_s4.sign, 10'd0, qr_c[52:0]};
		end else if (qr_c[53]) begin
			if (be_inc_c >= $signed({7'd0, DBL_EXP_MAX})) res_c = {flg_s4.sign, DBL_INF[62:0]};
			else res_c = {flg_s4.sign, be_inc_c[10:0], 52'd0};
		end else begin
			if (be_s4 >= $signed({7'd0, DBL_EXP_MAX})) res_c = {flg_s4.sign, DBL_INF[62:0]};
			else res_c = {flg_s4.sign, bex_c, qr_c[51:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		flg_s1.sign <= ext_sign_exponent[15];
		flg_s1.inf  <= (ext_sign_exponent[14:0] == EXT_EXP_MAX);
		flg_s1.zero <= (ext_mantissa == 64'd0);
		ex_s1       <= ext_sign_exponent[14:0];
		mant_s1     <= ext_mantissa;

		flg_s2  <= flg_s1;
		ex_s2   <= ex_s1;
		mant_s2 <= mant_s1;
		lz_s2   <= lz_c;

		flg_s3 <= flg_s2;
		nm_s3  <= mant_s2 << lz_s2;
		be_s3  <= $signed({3'd0, ex_s2}) - BIAS_DIFF - $signed({12'd0, lz_s2});

		flg_s4   <= flg_s3;
		be_s4    <= be_s3;
		sub_s4   <= (be_s3 < 18'sd1);
		under_s4 <= (be_s3 < 18'sd1) && (shr_c > 18'sd64);
		q_s4     <= ext_c[116:64];
		grd_s4   <= ext_c[63];
		stk_s4   <= |ext_c[62:0];

		res_s5 <= res_c;
	end

	assign done = vld_s5;
	assign double_bits = res_s5;
endmodule

// ----- rtl/extended80_to_double_checker.sv -----
// ----------------------------------------------------------------------------
// extended80_to_double_checker
// Port-level timing and special-value checks, bound to the converter.
// ----------------------------------------------------------------------------
`include "extended80_to_double_assert.svh"

module extended80_to_double_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [15:0] ext_sign_exponent,
	input logic [63:0] ext_mantissa,
	input logic        done,
	input logic [63:0] double_bits
);
	import e80d_pkg::*;

	logic        in_inf;
	logic        in_zero;
	logic [63:0] inf_bits;

	assign in_inf   = start && (ext_sign_exponent[14:0] == EXT_EXP_MAX);
	assign in_zero  = start && (ext_mantissa == 64'd0) && (ext_sign_exponent[14:0] != EXT_EXP_MAX);
	assign inf_bits = {ext_sign_exponent[15], DBL_INF[62:0]};

	`E80D_ASSERT_ALWAYS(a_never_busy, !busy, "converter reported busy")
	`E80D_ASSERT_IMPL(a_req_done, start, ##5 done, "request gave no result")
	`E80D_ASSERT_IMPL(a_idle_quiet, !start, ##5 !done, "result without request")
	`E80D_ASSERT_IMPL(a_inf, in_inf, ##5 (double_bits == $past(inf_bits, 5)), "not infinity")
	`E80D_ASSERT_IMPL(a_zero, in_zero, ##5 (double_bits[62:0] == 63'd0), "zero mantissa not zero")
endmodule

bind extended80_to_double extended80_to_double_checker u_checker (.*);

// ----- bench/extended80_to_double_tb.sv -----
// ----------------------------------------------------------------------------
// extended80_to_double_tb
// Sends extended-precision requests to the converter and checks every
// binary64 result against a predictor that rounds once to nearest even.
// ----------------------------------------------------------------------------
module extended80_to_double_tb;
	import e80d_pkg::*;

	localparam int N_RANDOM = 800;
	localparam int CYCLE_LIMIT = 200000;

	class conversion_scoreboard;
		logic [63:0] pending_doubles[$];
		int n_errors = 0;

		// nearest-even rounding of an extended value to binary64 bits
		function automatic logic [63:0] to_double(logic [15:0] se, logic [63:0] mant);
			logic [63:0] sgn;
			logic [63:0] q;
			logic [63:0] rem;
			logic [63:0] half;
			logic [14:0] ex;
			int lz;
			int be;
			int sh;
			sgn = se[15] ? 64'h8000_0000_0000_0000 : 64'd0;
			ex = se[14:0];
			lz = 0;
			if (ex == EXT_EXP_MAX)
				return sgn | DBL_INF;
			if (mant == 64'd0)
				return sgn;
			while (!mant[63]) begin
				mant = mant << 1;
				lz++;
			end
			be = int'(ex) - 16383 - lz + 1023;
			if (be >= 1) begin
				q = mant >> 11;
				rem = {53'd0, mant[10:0]};
				if (rem > 64'h400 || (rem == 64'h400 && q[0]))
					q++;
				if (q == (64'd1 << 53)) begin
					q = q >> 1;
					be++;
				end
				if (be >= 2047)
					return sgn | DBL_INF;
				return sgn | (64'(be) << 52) | (q & 64'h000F_FFFF_FFFF_FFFF);
			end
			sh = 12 - be;
			if (sh > 64) begin
				q = 0;
			end else if (sh == 64) begin
				q = (mant > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
			end else begin
				q = mant >> sh;
				rem = mant & ((64'd1 << sh) - 1);
				half = 64'd1 << (sh - 1);
				if (rem > half || (rem == half && q[0]))
					q++;
			end
			return sgn | q;
		endfunction

		function void note_request(logic [15:0] se, logic [63:0] mant);
			pending_doubles.push_back(to_double(se, mant));
		endfunction

		function void check_result(logic [63:0] got);
			logic [63:0] want;
			if (pending_doubles.size() == 0) begin
				$error("double_bits: unexpected result %h", got);
				n_errors++;
				return;
			end
			want = pending_doubles.pop_front();
			if (got !== want) begin
				$error("double_bits: expected %h, actual %h", want, got);
				n_errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [15:0] ext_sign_exponent = '0;
	logic [63:0] ext_mantissa = '0;
	logic done;
	logic [63:0] double_bits;

	conversion_scoreboard sb = new();
	int cycle_count = 0;
	bit quiet_tail = 0;

	extended80_to_double i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && done)
			sb.check_result(double_bits);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// one request, with a random gap before it except near the end
	task automatic send_request(logic [15:0] se, logic [63:0] mant);
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			start <= 0;
			repeat (gap) @(negedge clk);
		end
		start <= 1;
		ext_sign_exponent <= se;
		ext_mantissa <= mant;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(se, mant);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_mant();
		logic [63:0] m;
		int lz;
		m = {$urandom(), $urandom()};
		case ($urandom_range(0, 5))
			0: begin
				lz = $urandom_range(0, 63);
				m = (m | 64'h8000_0000_0000_0000) >> lz;
			end
			1: m = {m[63:11], 1'b1, 10'd0};  // exact tie at the normal boundary
			2: m = m | 64'h8000_0000_0000_0000;
			3: m = {m[63:12], 12'hFFF} | 64'h8000_0000_0000_0000;
			default: ;
		endcase
		return m;
	endfunction

	function automatic logic [15:0] rand_se();
		logic [14:0] ex;
		case ($urandom_range(0, 5))
			0: ex = 15'(16383 - 1023 + $urandom_range(0, 130) - 65);  // subnormal edge
			1: ex = 15'(16383 + 1024 + $urandom_range(0, 8) - 4);    // overflow edge
			2: ex = 15'($urandom());
			default: ex = 15'(16383 + $urandom_range(0, 2000) - 1000);
		endcase
		if ($urandom_range(0, 40) == 0)
			ex = EXT_EXP_MAX;
		return {1'($urandom()), ex};
	endfunction

	initial begin
		repeat (7) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send_request(16'h0000, 64'd0);
		send_request(16'h8000, 64'd0);
		send_request(16'h7FFF, 64'd0);
		send_request(16'hFFFF, 64'hC000_0000_0000_0001);
		send_request(16'h3FFF, 64'h8000_0000_0000_0000);
		send_request(16'hBFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'h3FFF, 64'h8000_0000_0000_0400);
		send_request(16'h3FFF, 64'h8000_0000_0000_0C00);
		send_request(16'h43FE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'h43FF, 64'h8000_0000_0000_0000);
		send_request(16'h43FE, 64'hFFFF_FFFF_FFFF_F800);
		send_request(16'h3C01, 64'h8000_0000_0000_0000);
		send_request(16'h3C00, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'h3C00, 64'h8000_0000_0000_0000);
		send_request(16'h3BCD, 64'h8000_0000_0000_0000);
		send_request(16'h3BCC, 64'h8000_0000_0000_0000);
		send_request(16'h3BCC, 64'h8000_0000_0000_0001);
		send_request(16'h0000, 64'h0000_0000_0000_0001);
		send_request(16'h7FFE, 64'h0000_0000_0000_0001);
		send_request(16'h7FFE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_request(16'h5555, 64'h5555_5555_5555_5555);
		send_request(16'h2AAA, 64'hAAAA_AAAA_AAAA_AAAA);

		// hold off until the pipeline has drained
		start <= 0;
		while (sb.pending_doubles.size() != 0) @(negedge clk);

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM - 100)
				quiet_tail = 1;
			send_request(rand_se(), rand_mant());
		end
		start <= 0;

		while (sb.pending_doubles.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 5) @(negedge clk);
		if (sb.n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
